// File: hw/rtl/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types, codes and constants of the servo reply parser.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int MAX_VALUE_CHARS = 30;
  localparam int MAX_CMD_CHARS   = 4;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] MODE_ARM  = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [1:0] CFG_SERVO_ID = 2'd0;
  localparam logic [1:0] CFG_RESP_TO  = 2'd1;
  localparam logic [1:0] CFG_CHAR_TO  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_BADID   = 2'd2,
    ST_BADCMD  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SEARCH = 3'd1,
    PH_ID     = 3'd2,
    PH_CMD    = 3'd3,
    PH_VALUE  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  rx_byte;
    logic [31:0] expected_command;
    logic [2:0]  command_length;
  } srp_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] reply_value;
    logic               is_disabled_text;
  } srp_out_t;

  typedef struct packed {
    logic [7:0]  servo_id;
    logic [15:0] response_timeout_ms;
    logic [15:0] char_timeout_ms;
  } srp_cfg_t;

  function automatic logic [7:0] dis_char(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      2'd0:    c = 8'h44;
      2'd1:    c = 8'h49;
      2'd2:    c = 8'h53;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/srp_in_reg.sv
// ----------------------------------------------------------------------------
// srp_in_reg
// Input register: holds one transaction until the parser consumes it.
// ----------------------------------------------------------------------------
module srp_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  srp_pkg::srp_in_t in_data,
  input  logic             advance,
  output logic             item_vld,
  output srp_pkg::srp_in_t item
);
  import srp_pkg::*;

  logic    vld_r, vld_nxt;
  srp_in_t item_r;
  logic    load;

  assign in_stall = vld_r && !advance;
  assign load     = in_valid && !in_stall;
  assign vld_nxt  = load ? 1'b1 : (advance ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// File: hw/rtl/srp_core.sv
// ----------------------------------------------------------------------------
// srp_core
// Reply parser state and per-transaction update; produces at most one result.
// ----------------------------------------------------------------------------
module srp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  srp_pkg::srp_in_t  item,
  input  srp_pkg::srp_cfg_t cfg,
  output logic              emit,
  output srp_pkg::srp_out_t res
);
  import srp_pkg::*;

  typedef struct packed {
    phase_t      phase;
    logic [9:0]  id_acc;
    logic        id_seen;
    logic [31:0] letters;
    logic [2:0]  cmd_count;
    logic [2:0]  cmd_pos;
    logic [15:0] val_acc;
    logic        neg;
    logic        bad;
    logic [4:0]  val_cnt;
    logic [1:0]  dis_prog;
    logic [15:0] tick_count;
  } ctx_t;

  ctx_t ctx_r, ctx_nxt;

  logic [7:0]  c;
  logic        is_digit;
  logic [3:0]  digit;
  logic [13:0] id_sum;
  logic [9:0]  id_sat;
  logic        id_bad;
  logic [7:0]  letter;
  logic        letter_ok;
  logic [2:0]  pos_inc;
  logic [15:0] val_sum;
  logic [4:0]  cnt_inc;
  logic [15:0] tick_inc;
  logic [15:0] limit;
  logic [2:0]  len_clamp;
  logic        dis_step;

  assign c        = item.rx_byte;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit    = 4'(c - CH_ZERO);
  assign id_sum   = {1'b0, ctx_r.id_acc, 3'b000} + {3'b000, ctx_r.id_acc, 1'b0}
                    + {10'd0, digit};
  assign id_sat   = (id_sum > 14'd1023) ? 10'd1023 : id_sum[9:0];
  assign id_bad   = !ctx_r.id_seen || (ctx_r.id_acc != {2'b00, cfg.servo_id});
  assign letter   = ctx_r.cmd_pos[2] ? 8'h00
                    : 8'(ctx_r.letters >> {ctx_r.cmd_pos[1:0], 3'b000});
  assign letter_ok = (c == letter);
  assign pos_inc  = ctx_r.cmd_pos + 3'd1;
  assign val_sum  = {ctx_r.val_acc[12:0], 3'b000} + {ctx_r.val_acc[14:0], 1'b0}
                    + {12'd0, digit};
  assign cnt_inc  = ctx_r.val_cnt + 5'd1;
  assign tick_inc = (ctx_r.tick_count == 16'hFFFF) ? ctx_r.tick_count
                    : ctx_r.tick_count + 16'd1;
  assign limit    = (ctx_r.phase == PH_SEARCH) ? cfg.response_timeout_ms
                    : cfg.char_timeout_ms;
  assign len_clamp = (item.command_length == 3'd0) ? 3'd1
                    : (item.command_length > 3'(MAX_CMD_CHARS)) ? 3'(MAX_CMD_CHARS)
                    : item.command_length;
  assign dis_step = (ctx_r.val_cnt < 5'd3) && ({3'b000, ctx_r.dis_prog} == ctx_r.val_cnt)
                    && (c == dis_char(ctx_r.val_cnt[1:0]));

  function automatic srp_out_t finish(input ctx_t s);
    srp_out_t r;
    r.is_disabled_text = (s.dis_prog == 2'd3) && (s.val_cnt == 5'd3);
    if (s.bad) begin
      r.status      = ST_BADID;
      r.reply_value = '0;
    end else begin
      r.status      = ST_OK;
      r.reply_value = s.neg ? 16'(16'd0 - s.val_acc) : s.val_acc;
    end
    return r;
  endfunction

  function automatic srp_out_t fail(input status_t st);
    srp_out_t r;
    r.status           = st;
    r.reply_value      = '0;
    r.is_disabled_text = 1'b0;
    return r;
  endfunction

  always_comb begin
    ctx_nxt = ctx_r;
    emit    = 1'b0;
    res     = fail(ST_OK);
    if (fire) begin
      case (item.mode)
        MODE_ARM: begin
          ctx_nxt            = '0;
          ctx_nxt.phase      = PH_SEARCH;
          ctx_nxt.letters    = item.expected_command;
          ctx_nxt.cmd_count  = len_clamp;
        end
        MODE_BYTE: begin
          if (ctx_r.phase != PH_IDLE) begin
            ctx_nxt.tick_count = '0;
            case (ctx_r.phase)
              PH_SEARCH: begin
                if (c == CH_STAR) begin
                  ctx_nxt.phase = PH_ID;
                end
              end
              PH_ID, PH_CMD: begin
                if (ctx_r.phase == PH_ID && is_digit) begin
                  ctx_nxt.id_acc  = id_sat;
                  ctx_nxt.id_seen = 1'b1;
                end else if (ctx_r.phase == PH_ID && id_bad) begin
                  emit = 1'b1;
                  res  = fail(ST_BADID);
                end else if (!letter_ok) begin
                  emit = 1'b1;
                  res  = fail(ST_BADCMD);
                end else begin
                  ctx_nxt.cmd_pos = pos_inc;
                  ctx_nxt.phase   = (pos_inc >= ctx_r.cmd_count) ? PH_VALUE : PH_CMD;
                end
              end
              PH_VALUE: begin
                if (c == CH_CR) begin
                  emit = 1'b1;
                  res  = finish(ctx_r);
                end else begin
                  if (dis_step) begin
                    ctx_nxt.dis_prog = ctx_r.dis_prog + 2'd1;
                  end
                  if (is_digit) begin
                    ctx_nxt.val_acc = val_sum;
                  end else if (c == CH_MINUS) begin
                    ctx_nxt.neg = 1'b1;
                  end else begin
                    ctx_nxt.bad = 1'b1;
                  end
                  ctx_nxt.val_cnt = cnt_inc;
                  if (cnt_inc >= 5'(MAX_VALUE_CHARS)) begin
                    emit = 1'b1;
                    res  = finish(ctx_nxt);
                  end
                end
              end
              default: ;
            endcase
          end
        end
        MODE_TICK: begin
          if (ctx_r.phase != PH_IDLE) begin
            ctx_nxt.tick_count = tick_inc;
            if (tick_inc >= limit) begin
              emit = 1'b1;
              case (ctx_r.phase)
                PH_ID:   res = fail(id_bad ? ST_BADID : ST_BADCMD);
                PH_CMD:  res = fail(ST_BADCMD);
                default: res = fail(ST_TIMEOUT);
              endcase
            end
          end
        end
        default: ;
      endcase
      if (emit) begin
        ctx_nxt.phase = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
    end else begin
      ctx_r <= ctx_nxt;
    end
  end

endmodule

// File: hw/rtl/srp_out_reg.sv
// ----------------------------------------------------------------------------
// srp_out_reg
// Result register: holds a finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module srp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  srp_pkg::srp_out_t res,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output srp_pkg::srp_out_t out_data
);
  import srp_pkg::*;

  logic     vld_r, vld_nxt;
  srp_out_t data_r;

  assign advance = !vld_r || !out_stall;
  assign vld_nxt = load ? 1'b1 : (out_stall ? vld_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

// File: hw/rtl/servo_reply_parser.sv
// ----------------------------------------------------------------------------
// servo_reply_parser
// Parses a servo reply ('*', ID, command letters, value, CR) one transaction
// at a time and reports status, signed value and a DIS text flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : arm (mode 0), received byte (mode 1) or millisecond tick (mode 2).
//   out_* : one result per finished reply attempt; none for ignored items.
//   cfg_* : register writes (servo_id, response and character timeouts),
//           always ready; write only while the parser is idle.
// Order: an accepted transaction waits in the input register; parser state and
//   result register update together when it is consumed, presenting its result.
// Throughput: one transaction per cycle when no result is stalled; the whole
//   per-byte update sits between the input register and the result register.
// Stall: while out_stall holds a pending result, the parser stops consuming
//   and in_stall rises once the input register is full.
// Reset: parser idle, no result pending, servo_id 0, both timeouts 100.
// ----------------------------------------------------------------------------
module servo_reply_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  srp_pkg::srp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output srp_pkg::srp_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import srp_pkg::*;

  srp_cfg_t cfg_r, cfg_nxt;
  srp_in_t  item;
  srp_out_t res;
  logic     item_vld;
  logic     advance;
  logic     fire;
  logic     emit;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SERVO_ID: cfg_nxt.servo_id            = cfg_data[7:0];
        CFG_RESP_TO:  cfg_nxt.response_timeout_ms = cfg_data;
        CFG_CHAR_TO:  cfg_nxt.char_timeout_ms     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{servo_id: 8'd0, response_timeout_ms: TIMEOUT_RESET,
                 char_timeout_ms: TIMEOUT_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign fire = item_vld && advance;

  srp_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  srp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg_r),
    .emit  (emit),
    .res   (res)
  );

  srp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/srp_checker.sv
// ----------------------------------------------------------------------------
// srp_checker
// Port-level checks of the servo reply parser, bound to the top level.
// ----------------------------------------------------------------------------
module srp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input srp_pkg::srp_out_t out_data
);
  import srp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.reply_value == 16'sd0)
    else $error("nonzero value on failed reply");

  a_dis_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_disabled_text |-> out_data.status == ST_BADID)
    else $error("DIS flag without bad-number status");

  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no pending result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pending transaction after reset");

endmodule

bind servo_reply_parser srp_checker u_srp_checker (.*);
